// ===== design/utf8_stream_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Macros for concurrent checks in the decoder back end.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define U8DEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dec check failed");

// Antecedent holds in a cycle, consequent must hold in the following cycle.
`define U8DEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dec check failed");

`endif

// ===== design/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Byte classes and the record passed from the classifier to the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8dec_pkg;

  // Class of one input byte as seen by the front end.
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_INVALID
  } byte_kind_t;

  // Classified byte: its class, the payload bits that survive the prefix
  // mask, and the end-of-buffer flag.
  typedef struct packed {
    byte_kind_t  kind;
    logic [6:0]  payload;
    logic        last;
  } byte_class_t;

  localparam int unsigned CP_WIDTH  = 21;
  localparam int unsigned LEN_WIDTH = 3;

  // Classify a raw byte and strip its prefix bits.
  function automatic byte_class_t classify(input logic [7:0] b, input logic last);
    byte_class_t c;
    c.last = last;
    if (b[7] == 1'b0) begin
      c.kind    = KIND_ASCII;
      c.payload = b[6:0];
    end else if ((b & 8'hC0) == 8'h80) begin
      c.kind    = KIND_CONT;
      c.payload = {1'b0, b[5:0]};
    end else if ((b & 8'hE0) == 8'hC0) begin
      c.kind    = KIND_LEAD2;
      c.payload = {2'b0, b[4:0]};
    end else if ((b & 8'hF0) == 8'hE0) begin
      c.kind    = KIND_LEAD3;
      c.payload = {3'b0, b[3:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      c.kind    = KIND_LEAD4;
      c.payload = {4'b0, b[2:0]};
    end else begin
      c.kind    = KIND_INVALID;
      c.payload = 7'd0;
    end
    return c;
  endfunction

endpackage

// ===== design/u8dec_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts raw bytes, classifies them and holds one classified item for the
// queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8dec_front import u8dec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        cls_valid,
  input  logic        cls_ready,
  output byte_class_t cls_item
);

  logic        held;
  byte_class_t item;
  logic        take;

  // The stage is busy only while its item cannot move on to the queue.
  assign byte_stall = held && !cls_ready;
  assign take       = byte_valid && !byte_stall;

  // Classification register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (cls_ready) begin
      held <= 1'b0;
    end
    if (take) begin
      item <= classify(data_byte, end_of_buffer);
    end
  end

  assign cls_valid = held;
  assign cls_item  = item;

endmodule

// ===== design/u8dec_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder item queue
// Small FIFO of classified items between the front end and the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8dec_queue import u8dec_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  byte_class_t wr_item,
  output logic        rd_valid,
  input  logic        rd_ready,
  output byte_class_t rd_item
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  byte_class_t          slots [Depth];
  logic [PtrWidth-1:0]  wr_ptr;
  logic [PtrWidth-1:0]  rd_ptr;
  logic [CntWidth-1:0]  count;
  logic                 push;
  logic                 pop;

  assign wr_ready = (count != FullCnt);
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (push && !pop) begin
        count <= count + CntWidth'(1);
      end else if (pop && !push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== design/u8dec_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Runs the sequence state over classified items and registers the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_decoder_core_assert.svh"

module u8dec_back import u8dec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cls_valid,
  output logic                 cls_ready,
  input  byte_class_t          cls_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [CP_WIDTH-1:0]  code_point,
  output logic [LEN_WIDTH-1:0] seq_length,
  output logic                 decode_error
);

  logic [CP_WIDTH-1:0]  partial_value;
  logic [1:0]           bytes_remaining;
  logic [LEN_WIDTH-1:0] bytes_seen;

  logic [CP_WIDTH-1:0]  partial_value_next;
  logic [1:0]           bytes_remaining_next;
  logic [LEN_WIDTH-1:0] bytes_seen_next;
  logic                 emit;
  logic [CP_WIDTH-1:0]  emit_cp;
  logic [LEN_WIDTH-1:0] emit_len;
  logic                 emit_err;
  logic                 pop;
  logic [LEN_WIDTH-1:0] seen_inc;
  logic [CP_WIDTH-1:0]  shifted;

  // An item is taken whenever the output register is free or draining.
  assign cls_ready = !result_valid || !result_stall;
  assign pop       = cls_valid && cls_ready;
  assign seen_inc  = bytes_seen + LEN_WIDTH'(1);
  assign shifted   = {partial_value[CP_WIDTH-7:0], cls_item.payload[5:0]};

  // Sequence update for one item.
  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    bytes_seen_next      = bytes_seen;
    emit                 = 1'b0;
    emit_cp              = '0;
    emit_len             = LEN_WIDTH'(1);
    emit_err             = 1'b0;
    if (bytes_remaining == 2'd0) begin
      case (cls_item.kind)
        KIND_ASCII: begin
          emit    = 1'b1;
          emit_cp = CP_WIDTH'(cls_item.payload);
        end
        KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
          if (cls_item.last) begin
            // A lead byte at the end of the buffer is a truncated sequence.
            emit     = 1'b1;
            emit_err = 1'b1;
          end else begin
            partial_value_next = CP_WIDTH'(cls_item.payload);
            bytes_seen_next    = LEN_WIDTH'(1);
            if (cls_item.kind == KIND_LEAD2) begin
              bytes_remaining_next = 2'd1;
            end else if (cls_item.kind == KIND_LEAD3) begin
              bytes_remaining_next = 2'd2;
            end else begin
              bytes_remaining_next = 2'd3;
            end
          end
        end
        default: begin
          // Stray continuation or a lead that no sequence length allows.
          emit     = 1'b1;
          emit_err = 1'b1;
        end
      endcase
    end else if (cls_item.kind != KIND_CONT) begin
      // The offending byte is consumed along with the broken sequence.
      emit                 = 1'b1;
      emit_err             = 1'b1;
      emit_len             = seen_inc;
      partial_value_next   = '0;
      bytes_remaining_next = 2'd0;
      bytes_seen_next      = '0;
    end else begin
      partial_value_next   = shifted;
      bytes_remaining_next = bytes_remaining - 2'd1;
      bytes_seen_next      = seen_inc;
      if (bytes_remaining == 2'd1) begin
        emit     = 1'b1;
        emit_cp  = shifted;
        emit_len = seen_inc;
      end else if (cls_item.last) begin
        emit     = 1'b1;
        emit_err = 1'b1;
        emit_len = seen_inc;
      end
      if (bytes_remaining == 2'd1 || cls_item.last) begin
        partial_value_next   = '0;
        bytes_remaining_next = 2'd0;
        bytes_seen_next      = '0;
      end
    end
  end

  // Sequence state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= 2'd0;
      bytes_seen      <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (pop) begin
        partial_value   <= partial_value_next;
        bytes_remaining <= bytes_remaining_next;
        bytes_seen      <= bytes_seen_next;
      end
      if (pop && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (pop && emit) begin
      code_point   <= emit_cp;
      seq_length   <= emit_len;
      decode_error <= emit_err;
    end
  end

  // A sequence in progress has seen between one and three bytes.
  `U8DEC_ASSERT_IMPLY(a_seen_range, clk, rst, bytes_remaining != 2'd0,
                      bytes_seen != '0 && bytes_seen <= LEN_WIDTH'(3))
  // Error results carry a zero code point.
  `U8DEC_ASSERT_IMPLY(a_err_zero_cp, clk, rst, result_valid && decode_error,
                      code_point == '0)
  // A completed item leaves the state idle.
  `U8DEC_ASSERT_NEXT(a_idle_after_emit, clk, rst, pop && emit,
                     bytes_remaining == 2'd0 && bytes_seen == '0)

endmodule

// ===== design/utf8_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes a byte stream into code points with sequence length and error flag.
// ----------------------------------------------------------------------------
// The decoder takes one byte item per clock cycle, sustained, for as long as
// the result side keeps up. A byte passes through a classification register,
// a small queue of QueueDepth items and the decoder's result register before
// the result of the byte that completes or breaks its sequence is presented.
// Bytes that only extend a sequence give no result. Either side may stall at
// any time; the queue lets the front keep accepting while the result side
// is held, until the queue and the classification register are full.
`timescale 1ns / 1ps

module utf8_stream_decoder_core import u8dec_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [CP_WIDTH-1:0]  code_point,
  output logic [LEN_WIDTH-1:0] seq_length,
  output logic                 decode_error
);

  logic        fr_valid;
  logic        fr_ready;
  byte_class_t fr_item;
  logic        q_valid;
  logic        q_ready;
  byte_class_t q_item;

  // Byte classification.
  u8dec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .cls_valid     (fr_valid),
    .cls_ready     (fr_ready),
    .cls_item      (fr_item)
  );

  // Decoupling queue.
  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Sequence decoding and result register.
  u8dec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cls_valid    (q_valid),
    .cls_ready    (q_ready),
    .cls_item     (q_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .code_point   (code_point),
    .seq_length   (seq_length),
    .decode_error (decode_error)
  );

endmodule
